// ----- src/spam_pkg.sv -----
// Package for the sparse polynomial adder/multiplier: payload structs,
// opcodes, status codes and sizing constants. No dependencies.
`timescale 1ns / 1ps
package spam_pkg;

   localparam int MaxTermsDefault  = 8;
   localparam int CoeffBitsDefault = 16;
   localparam int ExpoBitsDefault  = 8;
   localparam int AccDepth         = 64;
   localparam int AccIdxBits       = 6;
   localparam int AccCntBits       = 7;
   localparam int OutCoeffBits     = 36;
   localparam int OutExpoBits      = 9;

   typedef enum logic [2:0] {
      OP_LOAD_A = 3'd0,
      OP_LOAD_B = 3'd1,
      OP_ADD    = 3'd2,
      OP_MUL    = 3'd3,
      OP_CLEAR  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_ORDER = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [15:0] term_coeff;
      logic [7:0]         term_expo;
   } req_word_type;

   typedef struct packed {
      logic signed [OutCoeffBits-1:0] out_coeff;
      logic [OutExpoBits-1:0]         out_expo;
      logic                           last_term;
      logic                           empty_result;
      logic [1:0]                     status;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load_a;      // store term into A
      logic load_b;
      logic clear_ab;
      logic merge_start; // begin a merge: add (src=AB) or one multiply row
      logic merge_mul;   // 1: merge acc with product row i, 0: merge A and B
      logic merge_step;  // advance one merge step
      logic copy_step;   // copy tmp entry back into acc
      logic acc_reset;   // acc_count <= 0
      logic emit_start;  // begin emitting from tmp
      logic emit_step;   // current emit entry taken
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic       merge_done;
      logic       copy_done;
      logic       emit_done;   // current entry is the final one
      logic       row_done;    // all A rows used
      logic [1:0] load_status;
   } sts_type;

endpackage

// ----- src/spam_datapath.sv -----
// Datapath: term stores, accumulator and temp memories, merge engine (add: one
// step a cycle; multiply: each step waits on the registered product or
// accumulator read) and the result-word formatter. Uses spam_pkg.
`timescale 1ns / 1ps
module spam_datapath
   import spam_pkg::*;
#(
   parameter int MAX_TERMS  = MaxTermsDefault,
   parameter int COEFF_BITS = CoeffBitsDefault,
   parameter int EXPO_BITS  = ExpoBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  ctl_type      ctl,
   output sts_type      sts,
   output rsp_word_type emit_word
);
   localparam int IdxBits = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CntBits = $clog2(MAX_TERMS + 1);
   localparam int PExpBits = EXPO_BITS + 1;

   logic signed [COEFF_BITS-1:0] a_coeffs [MAX_TERMS];
   logic [EXPO_BITS-1:0]         a_expos  [MAX_TERMS];
   logic signed [COEFF_BITS-1:0] b_coeffs [MAX_TERMS];
   logic [EXPO_BITS-1:0]         b_expos  [MAX_TERMS];
   logic [CntBits-1:0]           a_count_ff, b_count_ff;

   // acc and tmp memories, read data registered
   logic signed [OutCoeffBits-1:0] acc_c_mem [AccDepth];
   logic [PExpBits-1:0]            acc_e_mem [AccDepth];
   logic signed [OutCoeffBits-1:0] tmp_c_mem [AccDepth];
   logic [PExpBits-1:0]            tmp_e_mem [AccDepth];
   logic [AccCntBits-1:0]          acc_count_ff, tmp_count_ff;

   // merge indices
   logic [AccCntBits-1:0] x_idx_ff;   // acc index (or A index in add)
   logic [CntBits-1:0]    y_idx_ff;   // B index
   logic [CntBits-1:0]    row_ff;     // multiply row
   logic [AccCntBits-1:0] cp_idx_ff;
   logic [AccCntBits-1:0] em_idx_ff;
   logic                  mul_ff;

   // x side operand
   logic signed [OutCoeffBits-1:0] xc, yc, sum;
   logic [PExpBits-1:0]            xe, ye;
   logic                           x_ok, y_ok;
   logic signed [OutCoeffBits-1:0] prod_ff;
   logic [PExpBits-1:0]            pexp_ff;
   logic                           prod_vld_ff;
   logic signed [OutCoeffBits-1:0] accrd_c_ff;
   logic [PExpBits-1:0]            accrd_e_ff;
   logic                           accrd_vld_ff;
   logic [AccCntBits-1:0]          x_cnt;
   logic                           take_x, take_y, both, wr_en;
   logic signed [OutCoeffBits-1:0] wr_c;
   logic [PExpBits-1:0]            wr_e;
   logic                           full_w;
   logic [IdxBits-1:0]             a_last, b_last;
   logic [EXPO_BITS-1:0]           new_expo;

   assign x_cnt = mul_ff ? acc_count_ff : AccCntBits'(a_count_ff);
   assign x_ok  = x_idx_ff < x_cnt;
   assign y_ok  = y_idx_ff < b_count_ff;

   // x operand: acc read is registered, so merge steps wait for it
   always_comb begin
      if (mul_ff) begin
         xc = accrd_c_ff;
         xe = accrd_e_ff;
      end else begin
         xc = OutCoeffBits'(a_coeffs[x_idx_ff[IdxBits-1:0]]);
         xe = PExpBits'(a_expos[x_idx_ff[IdxBits-1:0]]);
      end
      if (mul_ff) begin
         yc = prod_ff;
         ye = pexp_ff;
      end else begin
         yc = OutCoeffBits'(b_coeffs[y_idx_ff[IdxBits-1:0]]);
         ye = PExpBits'(b_expos[y_idx_ff[IdxBits-1:0]]);
      end
   end

   assign sum    = xc + yc;
   assign full_w = tmp_count_ff == AccCntBits'(AccDepth);
   logic ops_rdy;
   assign ops_rdy = !mul_ff || ((accrd_vld_ff || !x_ok) && (prod_vld_ff || !y_ok));
   assign sts.merge_done = (!x_ok && !y_ok) || full_w;

   always_comb begin
      take_x = 1'b0;
      take_y = 1'b0;
      both   = 1'b0;
      if (x_ok && (!y_ok || xe > ye)) take_x = 1'b1;
      else if (y_ok && (!x_ok || ye > xe)) take_y = 1'b1;
      else if (x_ok && y_ok) both = 1'b1;
      wr_en = ctl.merge_step && ops_rdy && !sts.merge_done
              && (take_x || take_y || (both && sum != '0));
      wr_c  = take_x ? xc : (take_y ? yc : sum);
      wr_e  = take_x ? xe : ye;
   end

   assign a_last   = IdxBits'(a_count_ff - CntBits'(1));
   assign b_last   = IdxBits'(b_count_ff - CntBits'(1));
   assign new_expo = EXPO_BITS'(req_word.term_expo);

   always_comb begin
      sts.load_status = ST_OK;
      if (req_word.opcode == OP_LOAD_A) begin
         if (a_count_ff >= CntBits'(MAX_TERMS)) sts.load_status = ST_FULL;
         else if (a_count_ff != '0 && new_expo >= a_expos[a_last])
            sts.load_status = ST_ORDER;
      end else begin
         if (b_count_ff >= CntBits'(MAX_TERMS)) sts.load_status = ST_FULL;
         else if (b_count_ff != '0 && new_expo >= b_expos[b_last])
            sts.load_status = ST_ORDER;
      end
   end

   assign sts.copy_done = cp_idx_ff == tmp_count_ff;
   assign sts.row_done  = row_ff >= a_count_ff;
   assign sts.emit_done = (em_idx_ff + AccCntBits'(1)) >= tmp_count_ff;

   logic step_go;
   assign step_go = ctl.merge_step && ops_rdy && !sts.merge_done;

   // term stores and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff <= '0;
         b_count_ff <= '0;
      end else begin
         if (ctl.clear_ab) begin
            a_count_ff <= '0;
            b_count_ff <= '0;
         end
         if (ctl.load_a && sts.load_status == ST_OK) begin
            a_coeffs[a_count_ff[IdxBits-1:0]] <= COEFF_BITS'(req_word.term_coeff);
            a_expos[a_count_ff[IdxBits-1:0]]  <= new_expo;
            a_count_ff <= a_count_ff + CntBits'(1);
         end
         if (ctl.load_b && sts.load_status == ST_OK) begin
            b_coeffs[b_count_ff[IdxBits-1:0]] <= COEFF_BITS'(req_word.term_coeff);
            b_expos[b_count_ff[IdxBits-1:0]]  <= new_expo;
            b_count_ff <= b_count_ff + CntBits'(1);
         end
      end
   end

   // merge engine
   logic [AccCntBits-1:0] x_nxt;
   logic [CntBits-1:0]    y_nxt;
   assign x_nxt = (take_x || both) ? x_idx_ff + AccCntBits'(1) : x_idx_ff;
   assign y_nxt = (take_y || both) ? y_idx_ff + CntBits'(1) : y_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_count_ff <= '0;
         tmp_count_ff <= '0;
         x_idx_ff     <= '0;
         y_idx_ff     <= '0;
         row_ff       <= '0;
         cp_idx_ff    <= '0;
         em_idx_ff    <= '0;
         mul_ff       <= 1'b0;
         prod_vld_ff  <= 1'b0;
         accrd_vld_ff <= 1'b0;
      end else begin
         if (ctl.acc_reset) begin
            acc_count_ff <= '0;
            row_ff       <= '0;
         end
         if (ctl.merge_start) begin
            mul_ff       <= ctl.merge_mul;
            x_idx_ff     <= '0;
            y_idx_ff     <= '0;
            tmp_count_ff <= '0;
            prod_vld_ff  <= 1'b0;
            accrd_vld_ff <= 1'b0;
         end else if (ctl.merge_step) begin
            // operand fetch: product and acc entry registered, a taken
            // operand is fetched again
            if (step_go && (take_x || both)) accrd_vld_ff <= 1'b0;
            else if (!accrd_vld_ff) accrd_vld_ff <= 1'b1;
            if (step_go && (take_y || both)) prod_vld_ff <= 1'b0;
            else if (!prod_vld_ff) prod_vld_ff <= 1'b1;
            if (step_go) begin
               x_idx_ff <= x_nxt;
               y_idx_ff <= y_nxt;
               if (wr_en) tmp_count_ff <= tmp_count_ff + AccCntBits'(1);
            end
         end
         if (ctl.merge_step && sts.merge_done && mul_ff) begin
            cp_idx_ff <= '0;
         end
         if (ctl.copy_step) begin
            if (sts.copy_done) begin
               acc_count_ff <= tmp_count_ff;
               row_ff       <= row_ff + CntBits'(1);
               cp_idx_ff    <= '0;
            end else begin
               cp_idx_ff <= cp_idx_ff + AccCntBits'(1);
            end
         end
         if (ctl.emit_start) em_idx_ff <= '0;
         else if (ctl.emit_step) em_idx_ff <= em_idx_ff + AccCntBits'(1);
      end
   end

   // product register, refetched when invalid, and acc read register
   always_ff @(posedge clock) begin
      if (!prod_vld_ff || ctl.merge_start) begin
         prod_ff <= OutCoeffBits'(a_coeffs[row_ff[IdxBits-1:0]]
                    * b_coeffs[y_idx_ff[IdxBits-1:0]]);
         pexp_ff <= PExpBits'(a_expos[row_ff[IdxBits-1:0]])
                    + PExpBits'(b_expos[y_idx_ff[IdxBits-1:0]]);
      end
      accrd_c_ff <= acc_c_mem[x_idx_ff[AccIdxBits-1:0]];
      accrd_e_ff <= acc_e_mem[x_idx_ff[AccIdxBits-1:0]];
   end

   // tmp memory: merge writes, copy and emit reads
   logic signed [OutCoeffBits-1:0] tmprd_c_ff;
   logic [PExpBits-1:0]            tmprd_e_ff;
   logic [AccCntBits-1:0]          em_nxt;
   logic [AccCntBits-1:0]          rd_idx;
   // emit reads the entry the index moves to, so the word matches em_idx_ff
   assign em_nxt = ctl.emit_start ? '0
                   : (ctl.emit_step ? em_idx_ff + AccCntBits'(1) : em_idx_ff);
   assign rd_idx = ctl.copy_step ? cp_idx_ff : em_nxt;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tmp_c_mem[tmp_count_ff[AccIdxBits-1:0]] <= wr_c;
         tmp_e_mem[tmp_count_ff[AccIdxBits-1:0]] <= wr_e;
      end
      tmprd_c_ff <= tmp_c_mem[rd_idx[AccIdxBits-1:0]];
      tmprd_e_ff <= tmp_e_mem[rd_idx[AccIdxBits-1:0]];
   end

   // copy: read ahead through the tmp read register, write the registered data one index behind
   logic                  cp_wr_ff;
   logic [AccCntBits-1:0] cp_wa_ff;
   always_ff @(posedge clock) begin
      if (reset) cp_wr_ff <= 1'b0;
      else       cp_wr_ff <= ctl.copy_step && !sts.copy_done;
      cp_wa_ff <= cp_idx_ff;
      if (cp_wr_ff) begin
         acc_c_mem[cp_wa_ff[AccIdxBits-1:0]] <= tmprd_c_ff;
         acc_e_mem[cp_wa_ff[AccIdxBits-1:0]] <= tmprd_e_ff;
      end
   end

   always_comb begin
      emit_word.out_coeff    = tmprd_c_ff;
      emit_word.out_expo     = OutExpoBits'(tmprd_e_ff);
      emit_word.last_term    = sts.emit_done;
      emit_word.empty_result = tmp_count_ff == '0;
      emit_word.status       = ST_OK;
      if (tmp_count_ff == '0) emit_word.out_coeff = '0;
      if (tmp_count_ff == '0) emit_word.out_expo  = '0;
   end

endmodule

// ----- src/spam_control.sv -----
// Controller state machine: decodes commands, sequences merges, copies and
// the result stream, and owns the response register. Uses spam_pkg.
`timescale 1ns / 1ps
module spam_control
   import spam_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   output ctl_type      ctl,
   input  sts_type      sts,
   input  rsp_word_type emit_word
);
   typedef enum logic [2:0] {
      S_IDLE, S_MERGE, S_COPY, S_COPY_WAIT, S_EMIT_RD, S_EMIT
   } state_type;

   state_type    state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         mul_ff, mul_in;
   logic         acc_req;

   logic rsp_free;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && rsp_free);
   assign acc_req   = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      mul_in       = mul_ff;
      ctl          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (acc_req) begin
               unique case (req_word.opcode)
                  OP_LOAD_A, OP_LOAD_B: begin
                     ctl.load_a = req_word.opcode == OP_LOAD_A;
                     ctl.load_b = req_word.opcode == OP_LOAD_B;
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = '0;
                     rsp_word_in.last_term = 1'b1;
                     rsp_word_in.status    = sts.load_status;
                  end
                  OP_ADD: begin
                     ctl.merge_start = 1'b1;
                     mul_in   = 1'b0;
                     state_in = S_MERGE;
                  end
                  OP_MUL: begin
                     // merge_start empties tmp, so no rows emits an empty result
                     ctl.acc_reset   = 1'b1;
                     ctl.merge_start = 1'b1;
                     ctl.merge_mul   = 1'b1;
                     mul_in   = 1'b1;
                     state_in = S_COPY_WAIT;
                  end
                  OP_CLEAR: ctl.clear_ab = 1'b1;
                  default: ;
               endcase
            end
         end
         S_MERGE: begin
            ctl.merge_step = 1'b1;
            if (sts.merge_done) state_in = mul_ff ? S_COPY : S_EMIT_RD;
         end
         S_COPY: begin
            ctl.copy_step = 1'b1;
            if (sts.copy_done) state_in = S_COPY_WAIT;
         end
         S_COPY_WAIT: begin
            // start next row or emit accumulator; tmp holds the last merge
            if (sts.row_done) begin
               state_in = S_EMIT_RD;
            end else begin
               ctl.merge_start = 1'b1;
               ctl.merge_mul   = 1'b1;
               state_in        = S_MERGE;
            end
         end
         S_EMIT_RD: begin
            ctl.emit_start = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = emit_word;
               ctl.emit_step = 1'b1;
               if (emit_word.last_term) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_ff       <= mul_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- src/sparse_polynomial_add_multiply.sv -----
// Sparse polynomial add/multiply. A load gives its status word the cycle after
// it is taken. Add: one merge step a cycle, then S_EMIT_RD and S_EMIT give the
// first word through the response register. Multiply: per A row, a merge in
// which each step waits on the registered product or accumulator read, then a
// copy pass. Results stream one word a cycle while rsp_stall is low.
// Synchronous reset empties both stores.
`timescale 1ns / 1ps
module sparse_polynomial_add_multiply
   import spam_pkg::*;
#(
   parameter int MAX_TERMS  = MaxTermsDefault,
   parameter int COEFF_BITS = CoeffBitsDefault,
   parameter int EXPO_BITS  = ExpoBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);
   ctl_type      ctl;
   sts_type      sts;
   rsp_word_type emit_word;

   spam_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .rsp_valid, .rsp_stall, .rsp_word, .ctl, .sts, .emit_word
   );

   spam_datapath #(
      .MAX_TERMS(MAX_TERMS), .COEFF_BITS(COEFF_BITS), .EXPO_BITS(EXPO_BITS)
   ) u_datapath (
      .clock, .reset, .req_word, .ctl, .sts, .emit_word
   );

endmodule

// ----- src/spam_checker.sv -----
// Port-level assertions for the sparse polynomial block, bound to the top level.
// Uses spam_pkg.
`timescale 1ns / 1ps
module spam_props
   import spam_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.opcode == OP_LOAD_A |=>
      rsp_valid && rsp_word.last_term && !rsp_word.empty_result)
      else $error("load gave no status word");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.empty_result |-> rsp_word.last_term
      && rsp_word.out_coeff == '0 && rsp_word.status == ST_OK)
      else $error("bad empty word");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status != 2'd3)
      else $error("bad status");
endmodule

bind sparse_polynomial_add_multiply spam_props u_spam_props (.*);
